// ===== rtl/core/ckrs_pkg.sv =====
`timescale 1ns / 1ps

package ckrs_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_PIXELS = 65536;
   localparam int DEF_MAX_SIDE   = 256;

   // Fixed field widths
   localparam int PIX_IDX_W   = 16;
   localparam int COLOR_W     = 8;
   localparam int EDGE_W      = 16;
   localparam int DIM_W       = 9;
   localparam int COORD_OUT_W = 9;
   localparam int REQ_DATA_W  = 104;
   localparam int RSP_DATA_W  = 24;

   // Key colour: magenta
   localparam logic [COLOR_W-1:0] KEY_RED   = 8'hFF;
   localparam logic [COLOR_W-1:0] KEY_GREEN = 8'h00;
   localparam logic [COLOR_W-1:0] KEY_BLUE  = 8'hFF;

   localparam logic [COORD_OUT_W-1:0] NO_HIT_COORD = 9'h1FF;
   localparam logic [DIM_W-1:0]       DIM_RESET    = 9'd256;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_SETUP,
      ST_SCAN,
      ST_RESP
   } state_type;

   // Controller -> datapath
   typedef struct packed {
      logic write;     // store one pixel from the request
      logic capture;   // latch query rectangle
      logic clamp;     // clamp rectangle, preset miss result
      logic setup;     // load scan position and row base
      logic step;      // issue next read / check returned bit
      logic load_rsp;  // move result into the output register
   } cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic empty;     // clamped area holds no pixel
      logic done;      // scan finished (hit found or last pixel checked)
      logic rsp_free;  // output register can take a result this cycle
   } sts_type;

endpackage

// ===== rtl/core/ckrs_ctrl.sv =====
`timescale 1ns / 1ps

module ckrs_ctrl
   import ckrs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   input  logic    req_op,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && (req_op == OP_QUERY)) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            state_in = sts.empty ? ST_RESP : ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (sts.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.write   = req_tvalid && (req_op == OP_WRITE);
            cmd.capture = req_tvalid && (req_op == OP_QUERY);
         end
         ST_CLAMP: begin
            cmd.clamp = 1'b1;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
         end
         ST_RESP: begin
            cmd.load_rsp = sts.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== rtl/core/ckrs_datapath.sv =====
`timescale 1ns / 1ps

module ckrs_datapath
   import ckrs_pkg::*;
#(
   parameter int MAX_PIXELS = DEF_MAX_PIXELS,
   parameter int MAX_SIDE   = DEF_MAX_SIDE
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   output sts_type                       sts,
   // configuration write
   input  logic                          csr_we,
   input  logic [0:0]                    csr_index,
   input  logic [DIM_W-1:0]              csr_data,
   // request fields
   input  logic [PIX_IDX_W-1:0]          pixel_index,
   input  logic [COLOR_W-1:0]            red,
   input  logic [COLOR_W-1:0]            green,
   input  logic [COLOR_W-1:0]            blue,
   input  logic signed [EDGE_W-1:0]      left,
   input  logic signed [EDGE_W-1:0]      top,
   input  logic signed [EDGE_W-1:0]      right,
   input  logic signed [EDGE_W-1:0]      bottom,
   // result register
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic [COORD_OUT_W-1:0]        rsp_x,
   output logic [COORD_OUT_W-1:0]        rsp_y
);

   localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
   localparam int COORD_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int IDX_W   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1;
   localparam int ADDR_W  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

   // ---------------- configuration ----------------
   logic [DIM_W-1:0]  width_ff;
   logic [DIM_W-1:0]  height_ff;
   logic [SIDE_W-1:0] w_side;
   logic [SIDE_W-1:0] h_side;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_IMAGE_WIDTH:  width_ff  <= csr_data;
            REG_IMAGE_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // side values are clamped into 1..MAX_SIDE
   always_comb begin
      if (width_ff == '0) begin
         w_side = SIDE_W'(1);
      end else if (int'(width_ff) > MAX_SIDE) begin
         w_side = SIDE_W'(MAX_SIDE);
      end else begin
         w_side = SIDE_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_side = SIDE_W'(1);
      end else if (int'(height_ff) > MAX_SIDE) begin
         h_side = SIDE_W'(MAX_SIDE);
      end else begin
         h_side = SIDE_W'(height_ff);
      end
   end

   // ---------------- pixel store ----------------
   logic              key_mark_mem [0:MAX_PIXELS-1];
   logic              wr_ok;
   logic [ADDR_W-1:0] wr_addr;
   logic              wr_bit;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              rd_bit_ff;

   assign wr_ok   = 32'(pixel_index) < 32'(MAX_PIXELS);
   assign wr_addr = ADDR_W'(pixel_index);
   assign wr_bit  = (red == KEY_RED) && (green == KEY_GREEN) && (blue == KEY_BLUE);

   always_ff @(posedge clock) begin
      if (cmd.write && wr_ok) begin
         key_mark_mem[wr_addr] <= wr_bit;
      end
      if (rd_en) begin
         rd_bit_ff <= key_mark_mem[rd_addr];
      end
   end

   // ---------------- rectangle capture and clamp ----------------
   logic signed [EDGE_W-1:0] left_ff, top_ff, right_ff, bottom_ff;
   logic signed [EDGE_W:0]   x0_s, x1_s, y0_s, y1_s, w_last, h_last;
   logic [COORD_W-1:0]       x0_ff, x1_ff, y0_ff, y1_ff;
   logic                     empty_ff;
   logic                     empty_in;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         left_ff   <= left;
         top_ff    <= top;
         right_ff  <= right;
         bottom_ff <= bottom;
      end
   end

   always_comb begin
      w_last = signed'((EDGE_W + 1)'(w_side)) - 17'sd1;
      h_last = signed'((EDGE_W + 1)'(h_side)) - 17'sd1;
      x0_s   = {left_ff[EDGE_W-1], left_ff};
      y0_s   = {top_ff[EDGE_W-1], top_ff};
      x1_s   = {right_ff[EDGE_W-1], right_ff};
      y1_s   = {bottom_ff[EDGE_W-1], bottom_ff};
      if (left_ff[EDGE_W-1]) begin
         x0_s = '0;
      end
      if (top_ff[EDGE_W-1]) begin
         y0_s = '0;
      end
      if (x1_s > w_last) begin
         x1_s = w_last;
      end
      if (y1_s > h_last) begin
         y1_s = h_last;
      end
      empty_in = (x0_s > x1_s) || (y0_s > y1_s);
   end

   // when not empty all four bounds lie inside the image, so they fit COORD_W
   always_ff @(posedge clock) begin
      if (cmd.clamp) begin
         x0_ff    <= COORD_W'(x0_s);
         x1_ff    <= COORD_W'(x1_s);
         y0_ff    <= COORD_W'(y0_s);
         y1_ff    <= COORD_W'(y1_s);
         empty_ff <= empty_in;
      end
   end

   // ---------------- scan ----------------
   logic [COORD_W-1:0] x_ff, y_ff;
   logic [IDX_W-1:0]   base_ff;
   logic [IDX_W-1:0]   idx;
   logic               in_range;
   logic               issue_done_ff;
   logic               x_last, y_last;
   logic               pend_ff, pend_ok_ff, pend_last_ff;
   logic [COORD_W-1:0] pend_x_ff, pend_y_ff;
   logic               found;
   logic               last_checked;

   assign idx      = base_ff + IDX_W'(x_ff);
   assign in_range = 32'(idx) < 32'(MAX_PIXELS);
   assign rd_addr  = ADDR_W'(idx);
   assign rd_en    = cmd.step && !issue_done_ff && in_range;
   assign x_last   = (x_ff == x1_ff);
   assign y_last   = (y_ff == y1_ff);

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         x_ff    <= x0_ff;
         y_ff    <= y0_ff;
         base_ff <= IDX_W'(y0_ff * w_side);
      end else if (cmd.step && !issue_done_ff) begin
         if (x_last) begin
            x_ff <= x0_ff;
            if (!y_last) begin
               y_ff    <= y_ff + COORD_W'(1);
               base_ff <= base_ff + IDX_W'(w_side);
            end
         end else begin
            x_ff <= x_ff + COORD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_done_ff <= 1'b0;
         pend_ff       <= 1'b0;
      end else if (cmd.setup) begin
         issue_done_ff <= 1'b0;
         pend_ff       <= 1'b0;
      end else if (cmd.step) begin
         pend_ff <= !issue_done_ff;
         if (x_last && y_last) begin
            issue_done_ff <= 1'b1;
         end
      end
   end

   // coordinates are registered alongside the read so they arrive with the returned bit
   always_ff @(posedge clock) begin
      if (cmd.step && !issue_done_ff) begin
         pend_x_ff    <= x_ff;
         pend_y_ff    <= y_ff;
         pend_ok_ff   <= in_range;
         pend_last_ff <= x_last && y_last;
      end
   end

   assign found        = cmd.step && pend_ff && pend_ok_ff && rd_bit_ff;
   assign last_checked = cmd.step && pend_ff && pend_last_ff;

   // ---------------- result ----------------
   logic                   res_hit_ff;
   logic [COORD_OUT_W-1:0] res_x_ff, res_y_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic [COORD_OUT_W-1:0] rsp_x_ff, rsp_y_ff;

   always_ff @(posedge clock) begin
      if (cmd.clamp) begin
         res_hit_ff <= 1'b0;
         res_x_ff   <= NO_HIT_COORD;
         res_y_ff   <= NO_HIT_COORD;
      end else if (found) begin
         res_hit_ff <= 1'b1;
         res_x_ff   <= COORD_OUT_W'(pend_x_ff);
         res_y_ff   <= COORD_OUT_W'(pend_y_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_hit_ff <= res_hit_ff;
         rsp_x_ff   <= res_x_ff;
         rsp_y_ff   <= res_y_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;
   assign rsp_x     = rsp_x_ff;
   assign rsp_y     = rsp_y_ff;

   assign sts.empty    = empty_ff;
   assign sts.done     = found || last_checked;
   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;

endmodule

// ===== rtl/core/colour_key_rect_scan_top.sv =====
`timescale 1ns / 1ps
// Collision-image scanner.
// req_* stream: tuser = op. A write transaction (op 0) stores one pixel at
//   pixel_index; the pixel is marked when its colour is (255,0,255). A write
//   gives no response. A query transaction (op 1) gives a rectangle; it is
//   clamped to the image and scanned in row-major order.
// rsp_* stream: one transaction per query: hit flag in tuser, x and y of the
//   first marked pixel in tdata (-1,-1 when none or the area is empty).
// csr_* write channel: index 0 image_width, 1 image_height; always ready.
//   Write only while no query is in flight.
// Sequence: a query passes through clamp and row-base setup, then scans
//   one pixel per cycle through the registered memory read, stopping at the
//   first hit, then loads the response; an empty area skips the scan.
//   The scan is bounded by the single read port of the pixel store.
// One transaction is processed at a time; req_tready is high only while idle.
// The response register lets a new request in while a result waits; if
//   rsp_tready stays low a later query stops at its response step.
// Reset clears control state and sets both image sides to 256; the pixel
//   store is not cleared and must be written before it is queried.

module colour_key_rect_scan_top
   import ckrs_pkg::*;
#(
   parameter int MAX_PIXELS = DEF_MAX_PIXELS,
   parameter int MAX_SIDE   = DEF_MAX_SIDE
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [15:0] pixel_index, [23:16] red, [31:24] green, [39:32] blue,
   // [55:40] left, [71:56] top, [87:72] right, [103:88] bottom
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,   // [0] op
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [8:0] hit_x, [17:9] hit_y, [23:18] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,   // [0] hit
   // register write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [0:0]            csr_index,
   input  logic [DIM_W-1:0]      csr_data
);

   cmd_type                cmd;
   sts_type                sts;
   logic                   rsp_hit;
   logic [COORD_OUT_W-1:0] rsp_x;
   logic [COORD_OUT_W-1:0] rsp_y;

   // configuration is accepted every cycle
   assign csr_ready = 1'b1;

   ckrs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ckrs_datapath #(
      .MAX_PIXELS (MAX_PIXELS),
      .MAX_SIDE   (MAX_SIDE)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .csr_we      (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .pixel_index (req_tdata[15:0]),
      .red         (req_tdata[23:16]),
      .green       (req_tdata[31:24]),
      .blue        (req_tdata[39:32]),
      .left        (req_tdata[55:40]),
      .top         (req_tdata[71:56]),
      .right       (req_tdata[87:72]),
      .bottom      (req_tdata[103:88]),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_hit     (rsp_hit),
      .rsp_x       (rsp_x),
      .rsp_y       (rsp_y)
   );

   assign rsp_tdata = {6'b0, rsp_y, rsp_x};
   assign rsp_tuser = rsp_hit;

endmodule

// ===== rtl/core/ckrs_checker.sv =====
`timescale 1ns / 1ps

module ckrs_checker
   import ckrs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // a miss reports -1,-1
   a_miss_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         (rsp_tdata[8:0] == NO_HIT_COORD) && (rsp_tdata[17:9] == NO_HIT_COORD))
      else $error("miss without -1,-1 coordinates");

   // a query transaction blocks the request side while it is scanned
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_QUERY) |=> !req_tready)
      else $error("request accepted during a query");

   // reset leaves the block idle with no pending response
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

endmodule

bind colour_key_rect_scan_top ckrs_checker u_ckrs_checker (.*);
